// ===== src/tfcd_pkg.sv =====
`default_nettype none

package tfcd_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADSUM   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_USE_CHECKSUM = 2'd0,
    REG_END_FIRST    = 2'd1,
    REG_END_SECOND   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       use_checksum;
    logic [7:0] end_first;
    logic [7:0] end_second;
  } cfg_regs_t;

  // Decision on the byte currently offered at the input.
  typedef struct packed {
    logic [ADDR_W-1:0] wr_addr;
    logic              ends_frame;
    logic              overflow;
    logic              bad_sum;
    logic [ADDR_W-1:0] len;
  } frame_evt_t;

endpackage

`default_nettype wire

// ===== src/tfcd_scan.sv =====
`default_nettype none

module tfcd_scan import tfcd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_accept,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_regs_t  cfg,
  output frame_evt_t      evt
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [ADDR_W-1:0] ONE      = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] TWO      = ADDR_W'(2);

  logic [ADDR_W-1:0] count_r, count_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [7:0]        prev2_r, prev2_nxt;
  // Payload sums over the held bytes, and the same sum one and two bytes back.
  logic [7:0]        acc_r, acc_nxt;
  logic [7:0]        acc1_r, acc1_nxt;
  logic [7:0]        acc2_r, acc2_nxt;
  logic              zseen_r, zseen_nxt;
  logic [ADDR_W-1:0] zpos_r, zpos_nxt;

  logic              term;
  logic              ck;
  logic              full;
  logic [ADDR_W-1:0] limit;
  logic [ADDR_W-1:0] len;

  always_comb begin
    term  = (count_r != '0) && (rx_byte == cfg.end_second) && (prev_r == cfg.end_first);
    ck    = cfg.use_checksum && (count_r > TWO);
    limit = ck ? (count_r - TWO) : (count_r - ONE);
    len   = (zseen_r && (zpos_r < limit)) ? zpos_r : limit;
    full  = !term && (count_r == LAST_IDX);

    evt.wr_addr    = count_r;
    evt.ends_frame = term;
    evt.overflow   = full;
    evt.bad_sum    = ck && (acc2_r != prev2_r);
    evt.len        = len;
  end

  always_comb begin
    count_nxt = count_r;
    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    acc_nxt   = acc_r;
    acc1_nxt  = acc1_r;
    acc2_nxt  = acc2_r;
    zseen_nxt = zseen_r;
    zpos_nxt  = zpos_r;
    if (in_accept) begin
      if (term || full) begin
        count_nxt = '0;
        prev_nxt  = '0;
        prev2_nxt = '0;
        acc_nxt   = '0;
        acc1_nxt  = '0;
        acc2_nxt  = '0;
        zseen_nxt = 1'b0;
        zpos_nxt  = '0;
      end else begin
        count_nxt = count_r + ONE;
        prev2_nxt = prev_r;
        prev_nxt  = rx_byte;
        // Bytes after the first zero no longer belong to the payload.
        acc_nxt   = zseen_r ? acc_r : (acc_r + rx_byte);
        acc1_nxt  = acc_r;
        acc2_nxt  = acc1_r;
        if (!zseen_r && (rx_byte == 8'd0)) begin
          zseen_nxt = 1'b1;
          zpos_nxt  = count_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= '0;
      prev2_r <= '0;
      acc_r   <= '0;
      acc1_r  <= '0;
      acc2_r  <= '0;
      zseen_r <= 1'b0;
      zpos_r  <= '0;
    end else begin
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      acc_r   <= acc_nxt;
      acc1_r  <= acc1_nxt;
      acc2_r  <= acc2_nxt;
      zseen_r <= zseen_nxt;
      zpos_r  <= zpos_nxt;
    end
  end

  a_zero_pos_held : assert property (@(posedge clk) disable iff (!rst_n)
    zseen_r |-> (zpos_r < count_r))
    else $error("zero position outside held bytes");

  a_restart_after_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (term || full)) |=> (count_r == '0) && !zseen_r)
    else $error("fill count not cleared after frame end");

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    term |-> (len < count_r))
    else $error("payload length beyond held bytes");

endmodule

`default_nettype wire

// ===== src/terminated_frame_checksum_deframer.sv =====
// Terminated-frame deframer with an optional 8-bit sum checksum.
// Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per
// request; each byte is written into a 64-entry frame buffer (one write port,
// one registered read port). A frame ends on end-A directly followed by end-B.
// Result channel (out_valid/out_ready) carries out_payload_byte, out_status
// and out_last; out_last marks the final result caused by one input byte.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// holds use_checksum, end-A and end-B; write it only while the block is idle.
// Bytes that neither end a frame nor fill the buffer give no result. A byte
// that ends a frame or fills the buffer gives its first result in the next
// cycle. A good frame then drains from the buffer one payload byte per cycle
// while the receiver is ready, the registered read port driving the output
// byte; a status-only result is a single result with out_last set. While
// results are pending the input is held off. A stalled receiver simply
// freezes the drain with the current result held on the outputs.
// Reset empties the frame (no buffer clearing pass is needed) and restores
// checksums off, end-A 13 and end-B 10.
`default_nettype none

module terminated_frame_checksum_deframer import tfcd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic [1:0]      out_status,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DATA = 3'b010,
    S_STAT = 3'b100
  } state_t;

  localparam logic [ADDR_W-1:0] ONE = ADDR_W'(1);

  state_t            state_r, state_nxt;
  cfg_regs_t         cfg_r, cfg_nxt;
  status_t           stat_r, stat_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [7:0]        rdata_r;

  logic [7:0]        frame_mem [FRAME_BYTES];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_acc;
  logic              at_last;
  frame_evt_t        evt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tfcd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_acc),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .evt       (evt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_USE_CHECKSUM: cfg_nxt.use_checksum = cfg_data[0];
        REG_END_FIRST:    cfg_nxt.end_first    = cfg_data;
        REG_END_SECOND:   cfg_nxt.end_second   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  assign at_last = (idx_r == (len_r - ONE));

  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (evt.ends_frame) begin
            if (evt.bad_sum) begin
              state_nxt = S_STAT;
              stat_nxt  = ST_BADSUM;
            end else if (evt.len == '0) begin
              state_nxt = S_STAT;
              stat_nxt  = ST_EMPTY;
            end else begin
              // Start the drain: the first byte is read while the output loads.
              state_nxt = S_DATA;
              idx_nxt   = '0;
              len_nxt   = evt.len;
              rd_en     = 1'b1;
              rd_addr   = '0;
            end
          end else if (evt.overflow) begin
            state_nxt = S_STAT;
            stat_nxt  = ST_OVERFLOW;
          end
        end
      end
      S_DATA: begin
        if (out_ready) begin
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + ONE;
            rd_en   = 1'b1;
            rd_addr = idx_r + ONE;
          end
        end
      end
      S_STAT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame_mem[evt.wr_addr] <= in_rx_byte;
    end
    if (rd_en) begin
      rdata_r <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r   <= '{use_checksum: 1'b0, end_first: 8'd13, end_second: 8'd10};
      stat_r  <= ST_EMPTY;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cfg_r   <= cfg_nxt;
      stat_r  <= stat_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  assign out_valid        = (state_r != S_IDLE);
  assign out_payload_byte = (state_r == S_DATA) ? rdata_r : 8'd0;
  assign out_status       = (state_r == S_DATA) ? ST_DATA : stat_r;
  assign out_last         = (state_r == S_STAT) || ((state_r == S_DATA) && at_last);

  a_drain_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> (idx_r < len_r))
    else $error("drain index beyond payload length");

  a_last_frees_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("input not released after final result");

  a_drain_advances : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DATA) && out_ready && !at_last) |=> (idx_r == $past(idx_r) + ONE))
    else $error("drain index did not advance on accepted payload byte");

  a_status_nonzero_payload : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAT) |-> (stat_r != ST_DATA))
    else $error("status-only result carries data status");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tfcd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] payload;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct {
    bit         is_cfg;
    cfg_reg_t   idx;
    logic [7:0] data;
    bit         typed;
    status_t    status;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic [1:0] out_status;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  terminated_frame_checksum_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the block: buffer, fill level and register copies.
  logic [7:0]  frame_buf [FRAME_BYTES];
  int unsigned frame_fill;
  logic        cs_on;
  logic [7:0]  end_a;
  logic [7:0]  end_b;

  result_t     step_q[$];
  result_t     want_q[$];
  plan_row_t   plan[$];

  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  bit          typed_on = 1'b0;
  result_t     typed_res;

  function automatic int unsigned payload_length(input int unsigned limit);
    int unsigned n;
    n = 0;
    while (n < limit && frame_buf[n] != 8'h00) n++;
    return n;
  endfunction

  function automatic void emit_frame(input int unsigned len);
    int unsigned k;
    if (len == 0) begin
      step_q.push_back('{8'h00, ST_EMPTY, 1'b0});
    end else begin
      for (k = 0; k < len; k++) step_q.push_back('{frame_buf[k], ST_DATA, 1'b0});
    end
  endfunction

  // Results caused by one received byte, left in step_q.
  function automatic void deframe(input logic [7:0] b);
    int unsigned pos;
    int unsigned len;
    int unsigned k;
    logic [7:0]  sum;
    result_t     r;
    step_q.delete();
    pos = frame_fill;
    frame_buf[pos] = b;
    if (pos > 0 && b == end_b && frame_buf[pos - 1] == end_a) begin
      if (cs_on && pos > 2) begin
        len = payload_length(pos - 2);
        sum = 8'h00;
        for (k = 0; k < len; k++) sum = sum + frame_buf[k];
        if (sum == frame_buf[pos - 2]) begin
          emit_frame(len);
        end else begin
          step_q.push_back('{8'h00, ST_BADSUM, 1'b0});
        end
      end else begin
        emit_frame(payload_length(pos - 1));
      end
      frame_fill = 0;
    end else if (pos + 1 >= FRAME_BYTES) begin
      step_q.push_back('{8'h00, ST_OVERFLOW, 1'b0});
      frame_fill = 0;
    end else begin
      frame_fill = pos + 1;
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t w;
    int unsigned k;
    if (!rst_n) begin
      frame_fill = 0;
      cs_on = 1'b0;
      end_a = 8'd13;
      end_b = 8'd10;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_USE_CHECKSUM: cs_on = cfg_data[0];
          REG_END_FIRST:    end_a = cfg_data;
          REG_END_SECOND:   end_b = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        deframe(in_rx_byte);
        if (typed_on) begin
          want_q.push_back(typed_res);
        end else begin
          for (k = 0; k < step_q.size(); k++) want_q.push_back(step_q[k]);
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_payload_byte, status_t'(out_status), out_last};
        if (want_q.size() == 0) begin
          note_failure($sformatf("unexpected result: byte %02h status %0d last %0d",
                                 got.payload, got.status, got.last));
        end else begin
          w = want_q.pop_front();
          if (got.payload !== w.payload || got.status !== w.status ||
              got.last !== w.last) begin
            note_failure($sformatf(
              "mismatch: expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
              w.payload, w.status, w.last, got.payload, got.status, got.last));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every expected result has arrived and the block is quiet.
  task automatic settle();
    in_valid = 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned len, input bit allow_zero, input bit bad_sum);
    logic [7:0]  b;
    logic [7:0]  sum;
    bit          stopped;
    int unsigned k;
    sum = 8'h00;
    stopped = 1'b0;
    for (k = 0; k < len; k++) begin
      b = (allow_zero && $urandom_range(11) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      if (b == 8'h00) stopped = 1'b1;
      if (!stopped) sum = sum + b;
      send_byte(b);
    end
    if (cs_on) send_byte(bad_sum ? sum + 8'($urandom_range(255, 1)) : sum);
    send_byte(end_a);
    send_byte(end_b);
  endtask

  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 72) begin
      if ($urandom_range(19) == 0) n = $urandom_range(12, 7);
      else n = $urandom_range(6);
      send_frame(n, 1'b1, pick >= 60);
    end else if (pick < 88) begin
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) send_byte(8'($urandom));
    end else if (pick < 94) begin
      // A broken terminator: end-A followed by an arbitrary byte.
      send_byte(end_a);
      send_byte(8'($urandom));
    end else begin
      send_byte(end_b);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_sequence();
  endtask

  function automatic void add_byte(input logic [7:0] b, input bit typed, input status_t st);
    plan.push_back('{1'b0, REG_USE_CHECKSUM, b, typed, st});
  endfunction

  function automatic void add_cfg(input cfg_reg_t idx, input logic [7:0] d);
    plan.push_back('{1'b1, idx, d, 1'b0, ST_DATA});
  endfunction

  initial begin : stimulus
    int unsigned r;
    int unsigned k;
    logic [7:0]  a;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_USE_CHECKSUM;
    cfg_data = 8'h00;

    // Reset settings: no checksum, terminator 13 then 10.
    add_byte(8'd10, 1'b0, ST_DATA);     // end-B first in the buffer is plain data
    add_byte(8'h48, 1'b0, ST_DATA);
    add_byte(8'd13, 1'b0, ST_DATA);
    add_byte(8'd10, 1'b0, ST_DATA);
    add_byte(8'd13, 1'b0, ST_DATA);
    add_byte(8'd10, 1'b1, ST_EMPTY);
    add_byte(8'h01, 1'b0, ST_DATA);     // payload stops at the zero byte
    add_byte(8'h00, 1'b0, ST_DATA);
    add_byte(8'h05, 1'b0, ST_DATA);
    add_byte(8'd13, 1'b0, ST_DATA);
    add_byte(8'd10, 1'b0, ST_DATA);
    // Checksums on, terminator at the byte extremes.
    add_cfg(REG_USE_CHECKSUM, 8'h01);
    add_cfg(REG_END_FIRST, 8'hFF);
    add_cfg(REG_END_SECOND, 8'h00);
    add_byte(8'h03, 1'b0, ST_DATA);
    add_byte(8'h04, 1'b0, ST_DATA);
    add_byte(8'h07, 1'b0, ST_DATA);
    add_byte(8'hFF, 1'b0, ST_DATA);
    add_byte(8'h00, 1'b0, ST_DATA);
    add_byte(8'h03, 1'b0, ST_DATA);
    add_byte(8'h04, 1'b0, ST_DATA);
    add_byte(8'h08, 1'b0, ST_DATA);
    add_byte(8'hFF, 1'b0, ST_DATA);
    add_byte(8'h00, 1'b1, ST_BADSUM);
    add_byte(8'h05, 1'b0, ST_DATA);     // too short to carry a checksum
    add_byte(8'hFF, 1'b0, ST_DATA);
    add_byte(8'h00, 1'b0, ST_DATA);
    add_byte(8'hFF, 1'b0, ST_DATA);
    add_byte(8'h00, 1'b1, ST_EMPTY);

    tx_idle_pct = 19;
    rx_idle_pct = 61;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < plan.size(); r++) begin
      if (plan[r].is_cfg) begin
        settle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        typed_on = plan[r].typed;
        typed_res = '{8'h00, plan[r].status, 1'b1};
        send_byte(plan[r].data);
        typed_on = 1'b0;
      end
    end

    settle();
    write_reg(REG_USE_CHECKSUM, 8'h01);
    write_reg(REG_END_FIRST, 8'd13);
    write_reg(REG_END_SECOND, 8'd10);
    run_random(8);

    settle();
    tx_idle_pct = 61;
    rx_idle_pct = 19;
    write_reg(REG_USE_CHECKSUM, 8'h00);
    write_reg(REG_END_FIRST, 8'h00);
    write_reg(REG_END_SECOND, 8'hFF);
    // Receiver stalls while frames and more requests pile up.
    hold_asked++;
    send_frame(10, 1'b0, 1'b0);
    send_frame(3, 1'b1, 1'b0);
    // Nonzero bytes never match end-A here, so the buffer must overflow.
    for (k = 0; k < FRAME_BYTES; k++) send_byte(8'($urandom_range(255, 1)));

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    a = 8'($urandom_range(254, 1));
    write_reg(REG_USE_CHECKSUM, 8'h01);
    write_reg(REG_END_FIRST, a);
    write_reg(REG_END_SECOND, a);
    run_random(8);

    settle();
    repeat (20) @(negedge clk);
    if (failures == 0 && want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tfcd_pkg.sv
src/tfcd_scan.sv
src/terminated_frame_checksum_deframer.sv
tb/tb_top.sv
